// ===== src/id3_tfd_pkg.sv =====
package id3_tfd_pkg;

  // Frame decode mode, chosen by the encoding byte
  typedef enum logic [1:0] {
    MODE_PASS  = 2'd0,
    MODE_UTF16 = 2'd1,
    MODE_BAD   = 2'd2
  } mode_t;

  localparam logic [7:0]  BYTE_FF     = 8'hff;
  localparam logic [7:0]  BYTE_ZERO   = 8'h00;
  localparam logic [7:0]  ENC_LATIN1  = 8'h00;
  localparam logic [7:0]  ENC_UNSUPP  = 8'h03;
  localparam logic [7:0]  CHAR_DOT    = 8'h2e;
  localparam logic [15:0] BOM_LE      = 16'hfffe;
  localparam logic [15:0] BOM_BE      = 16'hfeff;

  // One result beat
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       bad_encoding;
    logic       end_of_text;
  } result_t;

endpackage

// ===== src/id3_tfd_in_reg.sv =====
module id3_tfd_in_reg
  import id3_tfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_frame_last,
  input  logic       advance,
  output logic       hold_valid,
  output logic [7:0] hold_byte,
  output logic       hold_last
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       take;

  // input register frees up whenever the decode stage consumes it
  assign in_stall = valid_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload beat capture
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_byte;
      last_r <= in_frame_last;
    end
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;
  assign hold_last  = last_r;

endmodule

// ===== src/id3_tfd_decode.sv =====
module id3_tfd_decode
  import id3_tfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] byte_in,
  input  logic       last_in,
  input  logic       unsync_en,
  output logic       emit,
  output result_t    res
);

  logic       ff_seen_r, ff_seen_nxt;
  logic       start_r, start_nxt;
  mode_t      mode_r, mode_nxt;
  logic [7:0] held_r, held_nxt;
  logic       half_r, half_nxt;
  logic       le_r, le_nxt;
  logic       mark_r, mark_nxt;
  logic       in_str_r, in_str_nxt;

  // per-byte decode, all frame state updated in one pass
  always_comb begin
    logic        drop;
    logic        have;
    logic [7:0]  ch;
    logic [15:0] unit;
    logic [7:0]  hi;
    logic [7:0]  lo;

    ff_seen_nxt = ff_seen_r;
    start_nxt   = start_r;
    mode_nxt    = mode_r;
    held_nxt    = held_r;
    half_nxt    = half_r;
    le_nxt      = le_r;
    mark_nxt    = mark_r;
    in_str_nxt  = in_str_r;
    drop        = 1'b0;
    have        = 1'b0;
    ch          = BYTE_ZERO;
    unit        = {held_r, byte_in};
    hi          = held_r;
    lo          = byte_in;

    // unsynchronisation: zero after FF is dropped
    if (unsync_en) begin
      if (ff_seen_r && (byte_in == BYTE_ZERO)) begin
        drop        = 1'b1;
        ff_seen_nxt = 1'b0;
      end else begin
        ff_seen_nxt = (byte_in == BYTE_FF);
      end
    end

    if (!drop) begin
      if (start_r) begin
        start_nxt = 1'b0;
        if (byte_in == ENC_LATIN1) begin
          mode_nxt = MODE_PASS;
        end else if (byte_in > ENC_UNSUPP) begin
          mode_nxt = MODE_PASS;
          ch       = byte_in;
          have     = 1'b1;
        end else if (byte_in == ENC_UNSUPP) begin
          mode_nxt = MODE_BAD;
        end else begin
          mode_nxt   = MODE_UTF16;
          in_str_nxt = 1'b0;
        end
      end else if (mode_r == MODE_PASS) begin
        ch   = byte_in;
        have = 1'b1;
      end else if (mode_r == MODE_UTF16) begin
        if (!half_r) begin
          held_nxt = byte_in;
          half_nxt = 1'b1;
        end else begin
          half_nxt = 1'b0;
          have     = 1'b1;
          // byte-order mark check at string start
          if (!in_str_r) begin
            in_str_nxt = 1'b1;
            if (unit == BOM_LE) begin
              mark_nxt = 1'b1;
              le_nxt   = 1'b1;
              have     = 1'b0;
            end else if (unit == BOM_BE) begin
              mark_nxt = 1'b1;
              le_nxt   = 1'b0;
              have     = 1'b0;
            end else if (!mark_r && (byte_in == BYTE_ZERO)) begin
              le_nxt = 1'b1;
            end
          end
          if (have) begin
            if (le_nxt) begin
              hi = byte_in;
              lo = held_r;
            end
            if (unit == 16'h0000) begin
              in_str_nxt = 1'b0;
              ch         = BYTE_ZERO;
            end else if (hi != BYTE_ZERO) begin
              ch = CHAR_DOT;
            end else begin
              ch = lo;
            end
          end
        end
      end
    end

    // frame end: result or bare end marker, then clear frame state
    res.out_char     = have ? ch : BYTE_ZERO;
    res.char_valid   = have;
    res.end_of_text  = last_in;
    res.bad_encoding = last_in && !have && !start_nxt &&
                       ((mode_nxt == MODE_BAD) || (mode_nxt == mode_t'(2'd3)));
    emit             = have || last_in;

    if (last_in) begin
      ff_seen_nxt = 1'b0;
      start_nxt   = 1'b1;
      mode_nxt    = MODE_PASS;
      held_nxt    = BYTE_ZERO;
      half_nxt    = 1'b0;
      le_nxt      = 1'b0;
      mark_nxt    = 1'b0;
      in_str_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_seen_r <= 1'b0;
      start_r   <= 1'b1;
      mode_r    <= MODE_PASS;
      held_r    <= BYTE_ZERO;
      half_r    <= 1'b0;
      le_r      <= 1'b0;
      mark_r    <= 1'b0;
      in_str_r  <= 1'b0;
    end else if (step) begin
      ff_seen_r <= ff_seen_nxt;
      start_r   <= start_nxt;
      mode_r    <= mode_nxt;
      held_r    <= held_nxt;
      half_r    <= half_nxt;
      le_r      <= le_nxt;
      mark_r    <= mark_nxt;
      in_str_r  <= in_str_nxt;
    end
  end

endmodule

// ===== src/id3_text_frame_decoder.sv =====
// ID3v2 text frame decoder.
// Input channel: one payload byte per beat (in_byte) with in_frame_last on
// the final byte of the frame; accepted when in_valid is high and in_stall
// low. Output channel: decoded characters (out_char, out_char_valid,
// out_bad_encoding, out_end_of_text), taken when out_valid is high and
// out_stall low. Each frame closes with a beat carrying out_end_of_text.
// Config channel: cfg_data[0] sets unsynchronisation removal; cfg_ready is
// always high. Write it only while the block is idle.
// A byte is decoded and its result registered and offered when the result
// register is free. Throughput: one byte per cycle when not stalled, set by
// the single decode stage between the input and result registers.
// Reset (synchronous, rst_n low) empties both registers and puts the frame
// state at frame start; unsynchronisation removal is off.
// When out_stall is high with a result pending, the input register takes at
// most one more byte and holds it; in_stall is high while that byte waits.
module id3_text_frame_decoder
  import id3_tfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_frame_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_char_valid,
  output logic       out_bad_encoding,
  output logic       out_end_of_text,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  logic       unsync_r;
  logic       advance;
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_last;
  logic       step;
  logic       emit;
  result_t    res;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_r;

  // config register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unsync_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unsync_r <= cfg_data;
    end
  end

  assign advance = !out_valid_r || !out_stall;
  assign step    = hold_valid && advance;

  id3_tfd_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_frame_last(in_frame_last),
    .advance      (advance),
    .hold_valid   (hold_valid),
    .hold_byte    (hold_byte),
    .hold_last    (hold_last)
  );

  id3_tfd_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .byte_in  (hold_byte),
    .last_in  (hold_last),
    .unsync_en(unsync_r),
    .emit     (emit),
    .res      (res)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (step && emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_char         = out_r.out_char;
  assign out_char_valid   = out_r.char_valid;
  assign out_bad_encoding = out_r.bad_encoding;
  assign out_end_of_text  = out_r.end_of_text;

endmodule
